### sv/wwb_pkg.sv
`default_nettype none

package wwb_pkg;

  localparam int unsigned MAP_BITS_DEF = 4096;
  localparam int unsigned WORD_BITS    = 64;
  localparam int unsigned POS_W        = 13;
  localparam int unsigned INDEX_W      = 12;
  localparam int unsigned COUNT_W      = 13;
  localparam int unsigned TYPE_W       = 3;

  typedef enum logic [TYPE_W-1:0] {
    REQ_CLEAR_ALL   = 3'd0,
    REQ_SET_BIT     = 3'd1,
    REQ_CLEAR_BIT   = 3'd2,
    REQ_TEST_BIT    = 3'd3,
    REQ_ANY_SET     = 3'd4,
    REQ_FIRST_SET   = 3'd5,
    REQ_ALL_SET     = 3'd6,
    REQ_FIRST_CLEAR = 3'd7
  } req_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic clear_all;
    logic read;
    logic step;
    logic single;
    logic load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic rem_zero;
    logic found;
    logic ev_busy;
    logic out_stall;
  } sts_t;

  function automatic logic is_window(input req_e t);
    return (t == REQ_ANY_SET) || (t == REQ_FIRST_SET) ||
           (t == REQ_ALL_SET) || (t == REQ_FIRST_CLEAR);
  endfunction

  function automatic logic wants_set(input req_e t);
    return (t == REQ_ANY_SET) || (t == REQ_FIRST_SET);
  endfunction

endpackage

`default_nettype wire

### sv/wwb_ctrl.sv
`default_nettype none

module wwb_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          s_tvalid_i,
  input  wire logic [2:0]    req_type_i,
  output logic               s_tready_o,
  input  wire wwb_pkg::sts_t sts_i,
  output wwb_pkg::cmd_t      cmd_o
);
  import wwb_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_READ   = 6'b000010,
    ST_SINGLE = 6'b000100,
    ST_SCAN   = 6'b001000,
    ST_DRAIN  = 6'b010000,
    ST_FINISH = 6'b100000
  } state_e;

  state_e state_q, state_d;
  req_e   req_type;
  logic   accept;

  assign req_type   = req_e'(req_type_i);
  assign s_tready_o = (state_q == ST_IDLE);
  assign accept     = s_tready_o && s_tvalid_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.accept    = 1'b1;
          cmd_o.clear_all = (req_type == REQ_CLEAR_ALL);
          if (req_type == REQ_CLEAR_ALL) begin
            state_d = ST_FINISH;
          end else if (is_window(req_type)) begin
            state_d = ST_SCAN;
          end else begin
            state_d = ST_READ;
          end
        end
      end
      ST_READ: begin
        cmd_o.read = 1'b1;
        state_d    = ST_SINGLE;
      end
      ST_SINGLE: begin
        cmd_o.single = 1'b1;
        state_d      = ST_FINISH;
      end
      ST_SCAN: begin
        if (sts_i.found || sts_i.rem_zero) begin
          state_d = ST_DRAIN;
        end else begin
          cmd_o.read = 1'b1;
          cmd_o.step = 1'b1;
        end
      end
      ST_DRAIN: begin
        if (!sts_i.ev_busy) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!sts_i.out_stall) begin
          cmd_o.load = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

### sv/wwb_datapath.sv
`default_nettype none

module wwb_datapath #(
  parameter int unsigned MAP_BITS = wwb_pkg::MAP_BITS_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire wwb_pkg::cmd_t cmd_i,
  output wwb_pkg::sts_t      sts_o,
  input  wire logic [2:0]    req_type_i,
  input  wire logic [11:0]   bit_index_i,
  input  wire logic [12:0]   range_count_i,
  input  wire logic          m_tready_i,
  output logic               m_tvalid_o,
  output logic               answer_flag_o,
  output logic [12:0]        found_position_o
);
  import wwb_pkg::*;

  localparam int unsigned WORDS = MAP_BITS / WORD_BITS;
  localparam int unsigned WAW   = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int unsigned PW    = $clog2(MAP_BITS);
  localparam int unsigned CW    = PW + 1;
  localparam int unsigned OW    = $clog2(WORD_BITS);

  // Word store; a word whose valid bit is low reads as all zeros.
  logic [WORD_BITS-1:0] mem [WORDS];
  logic [WORDS-1:0]     wvld_q;
  logic [WORD_BITS-1:0] rd_q;
  logic                 rd_vld_q;

  req_e            type_q;
  logic [PW-1:0]   cur_q;
  logic [CW-1:0]   rem_q;
  logic [POS_W-1:0] end_q;
  logic            found_q;
  logic [PW-1:0]   fpos_q;
  logic            bit_q;

  logic            ev_valid_q;
  logic [OW-1:0]   ev_off_q;
  logic [OW:0]     ev_n_q;
  logic [WAW-1:0]  ev_word_q;

  logic            out_valid_q;
  logic            out_flag_q;
  logic [POS_W-1:0] out_pos_q;

  // Request decode at accept.
  logic [PW+11:0]  idx_ext;
  logic [PW-1:0]   idx;
  logic [31:0]     cnt_wide;
  logic [CW-1:0]   cnt_sat;
  logic [CW-1:0]   end_sum;
  logic [CW-1:0]   end_wrap;
  logic [CW+12:0]  end_ext;

  assign idx_ext  = {{PW{1'b0}}, bit_index_i};
  assign idx      = idx_ext[PW-1:0];
  assign cnt_wide = {19'd0, range_count_i};
  assign cnt_sat  = (cnt_wide > MAP_BITS) ? CW'(MAP_BITS) : CW'(cnt_wide);
  assign end_sum  = {1'b0, idx} + cnt_sat;
  assign end_wrap = (end_sum > CW'(MAP_BITS)) ? (end_sum - CW'(MAP_BITS)) : end_sum;
  assign end_ext  = {13'd0, end_wrap};

  // Scan stepping: one word per cycle, stopping at the word end or the window end.
  logic [PW-1:0]  cur_shift;
  logic [WAW-1:0] cur_word;
  logic [OW-1:0]  cur_off;
  logic [OW:0]    avail;
  logic [OW:0]    step_n;

  assign cur_shift = cur_q >> OW;
  assign cur_word  = cur_shift[WAW-1:0];
  assign cur_off   = cur_q[OW-1:0];
  assign avail     = (OW+1)'(WORD_BITS) - {1'b0, cur_off};
  assign step_n    = (rem_q < CW'(avail)) ? (OW+1)'(rem_q) : avail;

  // Evaluation of the word returned by the store.
  logic [WORD_BITS-1:0] word;
  logic [WORD_BITS-1:0] cmp;
  logic [WORD_BITS-1:0] mask;
  logic [WORD_BITS-1:0] hit;
  logic [OW:0]          hi_lane;
  logic [OW-1:0]        lane;
  logic [PW-1:0]        hit_pos;

  assign word    = rd_vld_q ? rd_q : '0;
  assign cmp     = wants_set(type_q) ? word : ~word;
  assign hi_lane = {1'b0, ev_off_q} + ev_n_q;
  assign mask    = ({WORD_BITS{1'b1}} << ev_off_q) & ~({WORD_BITS{1'b1}} << hi_lane);
  assign hit     = cmp & mask;

  always_comb begin
    lane = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (hit[i]) begin
        lane = OW'(i);
      end
    end
  end

  assign hit_pos = (PW'(ev_word_q) << OW) | PW'(lane);

  // Single-bit read-modify-write.
  logic [WORD_BITS-1:0] wdata;
  logic                 wr_en;

  always_comb begin
    wdata = word;
    wdata[cur_off] = (type_q == REQ_SET_BIT);
  end
  assign wr_en = cmd_i.single && ((type_q == REQ_SET_BIT) || (type_q == REQ_CLEAR_BIT));

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[cur_word] <= wdata;
    end
    if (cmd_i.read) begin
      rd_q     <= mem[cur_word];
      rd_vld_q <= wvld_q[cur_word];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wvld_q <= '0;
    end else if (cmd_i.clear_all) begin
      wvld_q <= '0;
    end else if (wr_en) begin
      wvld_q[cur_word] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      type_q <= req_e'(req_type_i);
      cur_q  <= idx;
      rem_q  <= cnt_sat;
      end_q  <= end_ext[POS_W-1:0];
    end else if (cmd_i.step) begin
      cur_q <= cur_q + PW'(step_n);
      rem_q <= rem_q - CW'(step_n);
    end
    if (cmd_i.step) begin
      ev_off_q  <= cur_off;
      ev_n_q    <= step_n;
      ev_word_q <= cur_word;
    end
    if (cmd_i.single) begin
      bit_q <= word[cur_off];
    end
    if (ev_valid_q && !found_q && (|hit)) begin
      fpos_q <= hit_pos;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev_valid_q <= 1'b0;
      found_q    <= 1'b0;
    end else begin
      ev_valid_q <= cmd_i.step;
      if (cmd_i.accept) begin
        found_q <= 1'b0;
      end else if (ev_valid_q && (|hit)) begin
        found_q <= 1'b1;
      end
    end
  end

  // Result assembly.
  logic [PW+12:0]   fpos_ext;
  logic             res_flag;
  logic [POS_W-1:0] res_pos;

  assign fpos_ext = {13'd0, fpos_q};

  always_comb begin
    res_flag = 1'b0;
    res_pos  = '0;
    case (type_q)
      REQ_TEST_BIT:    res_flag = bit_q;
      REQ_ANY_SET:     res_flag = found_q;
      REQ_ALL_SET:     res_flag = !found_q;
      REQ_FIRST_SET,
      REQ_FIRST_CLEAR: res_pos  = found_q ? fpos_ext[POS_W-1:0] : end_q;
      default: begin
        res_flag = 1'b0;
        res_pos  = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_flag_q <= res_flag;
      out_pos_q  <= res_pos;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign m_tvalid_o       = out_valid_q;
  assign answer_flag_o    = out_flag_q;
  assign found_position_o = out_pos_q;

  assign sts_o.rem_zero  = (rem_q == '0);
  assign sts_o.found     = found_q;
  assign sts_o.ev_busy   = ev_valid_q;
  assign sts_o.out_stall = out_valid_q && !m_tready_i;

endmodule

`default_nettype wire

### sv/wrapped_window_bitmap.sv
// Channel    Dir  Payload
// s_axis     in   tuser[2:0] req_type; tdata[11:0] bit_index, [24:12] range_count
// m_axis     out  tdata[0] answer_flag, [13:1] found_position
//
// Clear-all goes from accept through FINISH to the output register; set,
// clear and test pass through READ, SINGLE and FINISH. A window query reads
// one 64-bit word per cycle through the single read port of the word store,
// wrapping past the map end, and it ends early at the first match.
// One request is in progress at a time; a finished result waits in the output
// register while the next request is taken. Reset is asynchronous, active low,
// and clears the map at once through per-word valid bits.
`default_nettype none

module wrapped_window_bitmap #(
  parameter int unsigned MAP_BITS = wwb_pkg::MAP_BITS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [31:0] s_axis_tdata_i,  // bit_index [11:0], range_count [24:12]
  input  wire logic [2:0]  s_axis_tuser_i,  // req_type [2:0]
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [15:0]      m_axis_tdata_o   // answer_flag [0], found_position [13:1]
);
  import wwb_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic             answer_flag;
  logic [POS_W-1:0] found_position;

  wwb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .req_type_i (s_axis_tuser_i),
    .s_tready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  wwb_datapath #(
    .MAP_BITS (MAP_BITS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .req_type_i       (s_axis_tuser_i),
    .bit_index_i      (s_axis_tdata_i[11:0]),
    .range_count_i    (s_axis_tdata_i[24:12]),
    .m_tready_i       (m_axis_tready_i),
    .m_tvalid_o       (m_axis_tvalid_o),
    .answer_flag_o    (answer_flag),
    .found_position_o (found_position)
  );

  assign m_axis_tdata_o = {2'b00, found_position, answer_flag};

endmodule

`default_nettype wire

### sv/wwb_checker.sv
`default_nettype none

module wwb_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid_i,
  input wire logic        s_axis_tready_o,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [15:0] m_axis_tdata_o
);

  logic [1:0] pend_q;
  logic       in_xfer;
  logic       out_xfer;

  assign in_xfer  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_xfer = m_axis_tvalid_o && m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 2'd0;
    end else begin
      pend_q <= pend_q + {1'b0, in_xfer} - {1'b0, out_xfer};
    end
  end

  // A result is only shown for a request that has been taken and not yet answered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (pend_q != 2'd0))
    else $error("result without a pending request");

  // At most one request in progress plus one result waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q == 2'd2) |-> !s_axis_tready_o)
    else $error("request taken while two are outstanding");

  // Flag results carry no position and find results carry no flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !(m_axis_tdata_o[0] && (m_axis_tdata_o[13:1] != 13'd0)))
    else $error("flag and position both set");

  // A stalled result holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> (m_axis_tvalid_o && $stable(m_axis_tdata_o)))
    else $error("stalled result changed");

endmodule

bind wrapped_window_bitmap wwb_checker u_wwb_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

`default_nettype wire
